// ----- hw/rtl/cesf_pkg.sv -----
// shared types and constants for the state-feedback controller with current observer
package cesf_pkg;

    localparam int C_DW     = 16;
    localparam int C_FRAC   = 12;
    localparam int C_VAL_W  = 22;
    localparam int C_PROD_W = C_DW + C_VAL_W;
    localparam int C_ACC_W  = C_PROD_W + 2;
    localparam int C_RND_W  = C_ACC_W - C_FRAC;
    localparam int C_CFG_W  = 64;
    localparam int C_IDX_W  = 3;

    localparam logic [C_IDX_W-1:0] CFG_FEEDBACK_GAINS = 3'd0;
    localparam logic [C_IDX_W-1:0] CFG_MODEL_A        = 3'd1;
    localparam logic [C_IDX_W-1:0] CFG_MODEL_B_C      = 3'd2;
    localparam logic [C_IDX_W-1:0] CFG_OBSERVER_GAIN  = 3'd3;
    localparam logic [C_IDX_W-1:0] CFG_DRIVE_OFFSET   = 3'd4;
    localparam logic [C_IDX_W-1:0] CFG_DRIVE_MIN      = 3'd5;
    localparam logic [C_IDX_W-1:0] CFG_DRIVE_MAX      = 3'd6;

    localparam logic signed [C_DW-1:0] C_DRIVE_MAX_RST = 16'sd16384;

    typedef enum logic [4:0] {
        S_IDLE,
        S_T0_K0, S_T0_K1, S_T0_K2, S_T0_KE, S_T0_U,
        S_T0_Z1A, S_T0_Z1B, S_T0_Z1, S_T0_Z2A, S_T0_Z2B, S_T0_Z2,
        S_T1_C1, S_T1_C2, S_T1_CE, S_T1_IN, S_T1_L1, S_T1_L2, S_T1_X1, S_T1_X2,
        S_FIN
    } t_state;

    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_K0_S, MUL_K1_X1, MUL_K2_X2,
        MUL_A11_X1, MUL_A12_X2, MUL_B1_U,
        MUL_A21_X1, MUL_A22_X2, MUL_B2_U,
        MUL_C1_Z1, MUL_C2_Z2,
        MUL_L1_IN, MUL_L2_IN
    } t_mul_sel;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD,
        ACC_SUB
    } t_acc_op;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_U,
        WR_Z1,
        WR_Z2,
        WR_INNOV,
        WR_X1,
        WR_X2
    } t_wr_op;

    typedef struct packed {
        logic     load_in;
        t_mul_sel mul_sel;
        t_acc_op  acc_op;
        t_wr_op   wr_op;
        logic     finish;
    } t_cmd;

    typedef struct packed {
        logic out_full;
    } t_status;

endpackage

// ----- hw/rtl/cesf_ctrl.sv -----
// sequencer for the shared multiply-accumulate steps of one item
module cesf_ctrl
    import cesf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_in_req_type,
    input  logic    i_out_ready,
    input  t_status i_status,
    output logic    o_in_ready,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state        = r_state;
        o_in_ready     = 1'b0;
        o_cmd.load_in  = 1'b0;
        o_cmd.mul_sel  = MUL_NONE;
        o_cmd.acc_op   = ACC_HOLD;
        o_cmd.wr_op    = WR_NONE;
        o_cmd.finish   = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = i_in_req_type ? S_T1_C1 : S_T0_K0;
                end
            end
            S_T0_K0: begin
                o_cmd.mul_sel = MUL_K0_S;
                n_state = S_T0_K1;
            end
            S_T0_K1: begin
                o_cmd.mul_sel = MUL_K1_X1;
                o_cmd.acc_op  = ACC_LOAD;
                n_state = S_T0_K2;
            end
            S_T0_K2: begin
                o_cmd.mul_sel = MUL_K2_X2;
                o_cmd.acc_op  = ACC_SUB;
                n_state = S_T0_KE;
            end
            S_T0_KE: begin
                o_cmd.mul_sel = MUL_A11_X1;
                o_cmd.acc_op  = ACC_SUB;
                n_state = S_T0_U;
            end
            S_T0_U: begin
                o_cmd.wr_op   = WR_U;
                o_cmd.mul_sel = MUL_A12_X2;
                o_cmd.acc_op  = ACC_LOAD;
                n_state = S_T0_Z1A;
            end
            S_T0_Z1A: begin
                o_cmd.mul_sel = MUL_B1_U;
                o_cmd.acc_op  = ACC_ADD;
                n_state = S_T0_Z1B;
            end
            S_T0_Z1B: begin
                o_cmd.mul_sel = MUL_A21_X1;
                o_cmd.acc_op  = ACC_ADD;
                n_state = S_T0_Z1;
            end
            S_T0_Z1: begin
                o_cmd.wr_op   = WR_Z1;
                o_cmd.mul_sel = MUL_A22_X2;
                o_cmd.acc_op  = ACC_LOAD;
                n_state = S_T0_Z2A;
            end
            S_T0_Z2A: begin
                o_cmd.mul_sel = MUL_B2_U;
                o_cmd.acc_op  = ACC_ADD;
                n_state = S_T0_Z2B;
            end
            S_T0_Z2B: begin
                o_cmd.acc_op = ACC_ADD;
                n_state = S_T0_Z2;
            end
            S_T0_Z2: begin
                o_cmd.wr_op = WR_Z2;
                n_state = S_FIN;
            end
            S_T1_C1: begin
                o_cmd.mul_sel = MUL_C1_Z1;
                n_state = S_T1_C2;
            end
            S_T1_C2: begin
                o_cmd.mul_sel = MUL_C2_Z2;
                o_cmd.acc_op  = ACC_LOAD;
                n_state = S_T1_CE;
            end
            S_T1_CE: begin
                o_cmd.acc_op = ACC_ADD;
                n_state = S_T1_IN;
            end
            S_T1_IN: begin
                o_cmd.wr_op = WR_INNOV;
                n_state = S_T1_L1;
            end
            S_T1_L1: begin
                o_cmd.mul_sel = MUL_L1_IN;
                n_state = S_T1_L2;
            end
            S_T1_L2: begin
                o_cmd.mul_sel = MUL_L2_IN;
                o_cmd.acc_op  = ACC_LOAD;
                n_state = S_T1_X1;
            end
            S_T1_X1: begin
                o_cmd.wr_op  = WR_X1;
                o_cmd.acc_op = ACC_LOAD;
                n_state = S_T1_X2;
            end
            S_T1_X2: begin
                o_cmd.wr_op = WR_X2;
                n_state = S_FIN;
            end
            S_FIN: begin
                if (!i_status.out_full || i_out_ready) begin
                    o_cmd.finish = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ----- hw/rtl/cesf_dp.sv -----
// datapath: configuration, state, shared multiplier, accumulator and output register
module cesf_dp
    import cesf_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [C_IDX_W-1:0]       i_cfg_idx,
    input  logic [C_CFG_W-1:0]       i_cfg_data,
    input  logic                     i_in_req_type,
    input  logic signed [C_DW-1:0]   i_in_sample_value,
    input  logic                     i_out_ready,
    input  t_cmd                     i_cmd,
    output t_status                  o_status,
    output logic                     o_out_valid,
    output logic signed [C_DW-1:0]   o_out_drive,
    output logic                     o_out_drive_valid,
    output logic                     o_out_drive_clipped,
    output logic signed [C_DW-1:0]   o_out_estimate_first,
    output logic signed [C_DW-1:0]   o_out_estimate_second
);

    localparam logic signed [C_RND_W-1:0] C_SAT_HI = C_RND_W'((2 ** (C_DW - 1)) - 1);
    localparam logic signed [C_RND_W-1:0] C_SAT_LO = -C_SAT_HI - C_RND_W'(1);
    localparam logic signed [C_ACC_W-1:0] C_HALF   = C_ACC_W'(2 ** (C_FRAC - 1));

    logic [3*C_DW-1:0]          r_gains;
    logic [4*C_DW-1:0]          r_model_a;
    logic [4*C_DW-1:0]          r_model_bc;
    logic [2*C_DW-1:0]          r_obs;
    logic signed [C_DW-1:0]     r_offset;
    logic signed [C_DW-1:0]     r_dmin;
    logic signed [C_DW-1:0]     r_dmax;

    logic signed [C_DW-1:0]     r_x1, r_x2, r_z1, r_z2;
    logic                       r_type;
    logic signed [C_DW-1:0]     r_s;
    logic signed [C_VAL_W-1:0]  r_u;
    logic signed [C_VAL_W-1:0]  r_innov;
    logic signed [C_PROD_W-1:0] r_prod;
    logic signed [C_ACC_W-1:0]  r_acc;
    logic                       r_out_valid;

    logic signed [C_DW-1:0]     mul_a;
    logic signed [C_VAL_W-1:0]  mul_b;
    logic signed [C_PROD_W-1:0] prod_c;
    logic signed [C_ACC_W-1:0]  acc_half;
    logic signed [C_RND_W-1:0]  rnd;
    logic signed [C_RND_W-1:0]  upd1, upd2;
    logic signed [C_VAL_W:0]    d_lo, d_hi, d_raw, d_c1, d_c2;

    function automatic logic signed [C_DW-1:0] sat_dw(input logic signed [C_RND_W-1:0] v);
        logic signed [C_RND_W-1:0] t;
        t = v;
        if (v > C_SAT_HI) begin
            t = C_SAT_HI;
        end else if (v < C_SAT_LO) begin
            t = C_SAT_LO;
        end
        return t[C_DW-1:0];
    endfunction

    function automatic logic signed [C_VAL_W-1:0] ext_dw(input logic signed [C_DW-1:0] v);
        return C_VAL_W'(v);
    endfunction

    // operand selection for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.mul_sel)
            MUL_K0_S:   begin mul_a = r_gains[C_DW-1:0];          mul_b = ext_dw(r_s);  end
            MUL_K1_X1:  begin mul_a = r_gains[2*C_DW-1:C_DW];     mul_b = ext_dw(r_x1); end
            MUL_K2_X2:  begin mul_a = r_gains[3*C_DW-1:2*C_DW];   mul_b = ext_dw(r_x2); end
            MUL_A11_X1: begin mul_a = r_model_a[C_DW-1:0];        mul_b = ext_dw(r_x1); end
            MUL_A12_X2: begin mul_a = r_model_a[2*C_DW-1:C_DW];   mul_b = ext_dw(r_x2); end
            MUL_B1_U:   begin mul_a = r_model_bc[C_DW-1:0];       mul_b = r_u;          end
            MUL_A21_X1: begin mul_a = r_model_a[3*C_DW-1:2*C_DW]; mul_b = ext_dw(r_x1); end
            MUL_A22_X2: begin mul_a = r_model_a[4*C_DW-1:3*C_DW]; mul_b = ext_dw(r_x2); end
            MUL_B2_U:   begin mul_a = r_model_bc[2*C_DW-1:C_DW];  mul_b = r_u;          end
            MUL_C1_Z1:  begin mul_a = r_model_bc[3*C_DW-1:2*C_DW]; mul_b = ext_dw(r_z1); end
            MUL_C2_Z2:  begin mul_a = r_model_bc[4*C_DW-1:3*C_DW]; mul_b = ext_dw(r_z2); end
            MUL_L1_IN:  begin mul_a = r_obs[C_DW-1:0];            mul_b = r_innov;      end
            MUL_L2_IN:  begin mul_a = r_obs[2*C_DW-1:C_DW];       mul_b = r_innov;      end
            default:    begin mul_a = '0;                         mul_b = '0;           end
        endcase
    end

    assign prod_c = C_PROD_W'(mul_a) * C_PROD_W'(mul_b);

    // round half up then floor
    assign acc_half = r_acc + C_HALF;
    assign rnd      = acc_half[C_ACC_W-1:C_FRAC];
    assign upd1     = C_RND_W'(r_z1) + rnd;
    assign upd2     = C_RND_W'(r_z2) + rnd;

    // drive clamp
    assign d_lo  = (C_VAL_W + 1)'(r_dmin);
    assign d_hi  = (C_VAL_W + 1)'(r_dmax);
    assign d_raw = (C_VAL_W + 1)'(r_u) + (C_VAL_W + 1)'(r_offset);
    assign d_c1  = (d_raw < d_lo) ? d_lo : d_raw;
    assign d_c2  = (d_c1 > d_hi) ? d_hi : d_c1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gains    <= '0;
            r_model_a  <= '0;
            r_model_bc <= '0;
            r_obs      <= '0;
            r_offset   <= '0;
            r_dmin     <= '0;
            r_dmax     <= C_DRIVE_MAX_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FEEDBACK_GAINS: r_gains    <= i_cfg_data[3*C_DW-1:0];
                CFG_MODEL_A:        r_model_a  <= i_cfg_data[4*C_DW-1:0];
                CFG_MODEL_B_C:      r_model_bc <= i_cfg_data[4*C_DW-1:0];
                CFG_OBSERVER_GAIN:  r_obs      <= i_cfg_data[2*C_DW-1:0];
                CFG_DRIVE_OFFSET:   r_offset   <= i_cfg_data[C_DW-1:0];
                CFG_DRIVE_MIN:      r_dmin     <= i_cfg_data[C_DW-1:0];
                CFG_DRIVE_MAX:      r_dmax     <= i_cfg_data[C_DW-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x1 <= '0;
            r_x2 <= '0;
            r_z1 <= '0;
            r_z2 <= '0;
        end else begin
            case (i_cmd.wr_op)
                WR_Z1:   r_z1 <= sat_dw(rnd);
                WR_Z2:   r_z2 <= sat_dw(rnd);
                WR_X1:   r_x1 <= sat_dw(upd1);
                WR_X2:   r_x2 <= sat_dw(upd2);
                default: begin
                end
            endcase
        end
    end

    // working registers, payload only
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_type <= i_in_req_type;
            r_s    <= i_in_sample_value;
        end
        if (i_cmd.wr_op == WR_U) begin
            r_u <= rnd[C_VAL_W-1:0];
        end
        if (i_cmd.wr_op == WR_INNOV) begin
            r_innov <= ext_dw(r_s) - rnd[C_VAL_W-1:0];
        end
        r_prod <= prod_c;
        case (i_cmd.acc_op)
            ACC_LOAD: r_acc <= C_ACC_W'(r_prod);
            ACC_ADD:  r_acc <= r_acc + C_ACC_W'(r_prod);
            ACC_SUB:  r_acc <= r_acc - C_ACC_W'(r_prod);
            default:  r_acc <= r_acc;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            o_out_drive           <= r_type ? '0 : d_c2[C_DW-1:0];
            o_out_drive_valid     <= ~r_type;
            o_out_drive_clipped   <= r_type ? 1'b0 : (d_c2 != d_raw);
            o_out_estimate_first  <= r_x1;
            o_out_estimate_second <= r_x2;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_status.out_full = r_out_valid;

endmodule

// ----- hw/rtl/current_estimator_state_feedback_core.sv -----
// top level: state-feedback controller with current observer, one shared multiplier
// a reference item forms the drive and both predictions, a measurement item the innovation
// and both corrected estimates; the next item is taken only after the last one has finished
// the dependent products run one a cycle on the single multiplier
// the result sits in an output register, so a stalled result delays only the next finish
// synchronous active-low reset clears estimate, prediction and registers (drive_max to 4.0)
module current_estimator_state_feedback_core
    import cesf_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [C_IDX_W-1:0]     i_cfg_idx,
    input  logic [C_CFG_W-1:0]     i_cfg_data,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic                   i_in_req_type,
    input  logic signed [C_DW-1:0] i_in_sample_value,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic signed [C_DW-1:0] o_out_drive,
    output logic                   o_out_drive_valid,
    output logic                   o_out_drive_clipped,
    output logic signed [C_DW-1:0] o_out_estimate_first,
    output logic signed [C_DW-1:0] o_out_estimate_second
);

    t_cmd    cmd;
    t_status status;

    cesf_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_req_type (i_in_req_type),
        .i_out_ready   (i_out_ready),
        .i_status      (status),
        .o_in_ready    (o_in_ready),
        .o_cmd         (cmd)
    );

    cesf_dp u_dp (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cfg_we              (i_cfg_we),
        .i_cfg_idx             (i_cfg_idx),
        .i_cfg_data            (i_cfg_data),
        .i_in_req_type         (i_in_req_type),
        .i_in_sample_value     (i_in_sample_value),
        .i_out_ready           (i_out_ready),
        .i_cmd                 (cmd),
        .o_status              (status),
        .o_out_valid           (o_out_valid),
        .o_out_drive           (o_out_drive),
        .o_out_drive_valid     (o_out_drive_valid),
        .o_out_drive_clipped   (o_out_drive_clipped),
        .o_out_estimate_first  (o_out_estimate_first),
        .o_out_estimate_second (o_out_estimate_second)
    );

endmodule

// ----- tb/sv/tb_top.sv -----
// self-checking testbench for the state-feedback controller with current observer
module tb_top;
    import cesf_pkg::*;

    localparam int   N_PHASES    = 8;
    localparam int   PHASE_ITEMS = 175;
    localparam int   SETTLE      = 16;
    localparam int   CYCLE_LIMIT = 400000;

    localparam logic REQ_REFERENCE   = 1'b0;
    localparam logic REQ_MEASUREMENT = 1'b1;
    localparam logic [C_IDX_W-1:0] CFG_UNUSED = 3'd7;

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_ITEM,
        ROW_CHECKED
    } row_kind_t;

    typedef struct packed {
        logic signed [C_DW-1:0] drive;
        logic                   drive_valid;
        logic                   drive_clipped;
        logic signed [C_DW-1:0] est_first;
        logic signed [C_DW-1:0] est_second;
    } drive_result_t;

    typedef struct packed {
        row_kind_t            kind;
        logic [C_IDX_W-1:0]   idx;
        logic [C_CFG_W-1:0]   data;
        logic                 req_type;
        logic [C_DW-1:0]      sample;
        drive_result_t        given;
    } stim_row_t;

    typedef struct packed {
        logic [C_IDX_W-1:0] idx;
        logic [C_CFG_W-1:0] data;
    } reg_write_t;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [C_IDX_W-1:0]     i_cfg_idx;
    logic [C_CFG_W-1:0]     i_cfg_data;
    logic                   i_in_valid;
    logic                   o_in_ready;
    logic                   i_in_req_type;
    logic signed [C_DW-1:0] i_in_sample_value;
    logic                   o_out_valid;
    logic                   i_out_ready;
    logic signed [C_DW-1:0] o_out_drive;
    logic                   o_out_drive_valid;
    logic                   o_out_drive_clipped;
    logic signed [C_DW-1:0] o_out_estimate_first;
    logic signed [C_DW-1:0] o_out_estimate_second;

    current_estimator_state_feedback_core dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cfg_we              (i_cfg_we),
        .i_cfg_idx             (i_cfg_idx),
        .i_cfg_data            (i_cfg_data),
        .i_in_valid            (i_in_valid),
        .o_in_ready            (o_in_ready),
        .i_in_req_type         (i_in_req_type),
        .i_in_sample_value     (i_in_sample_value),
        .o_out_valid           (o_out_valid),
        .i_out_ready           (i_out_ready),
        .o_out_drive           (o_out_drive),
        .o_out_drive_valid     (o_out_drive_valid),
        .o_out_drive_clipped   (o_out_drive_clipped),
        .o_out_estimate_first  (o_out_estimate_first),
        .o_out_estimate_second (o_out_estimate_second)
    );

    // controller copy: registers, estimate and prediction
    logic [47:0]            fb_gains;
    logic [63:0]            mdl_a;
    logic [63:0]            mdl_bc;
    logic [31:0]            obs_gain;
    logic signed [C_DW-1:0] drv_ofs;
    logic signed [C_DW-1:0] drv_min;
    logic signed [C_DW-1:0] drv_max;
    longint                 est_st [2];
    longint                 pred_st [2];

    drive_result_t drive_estimate_q [$];
    reg_write_t    pending_writes [$];
    stim_row_t     directed_rows [$];

    int fails       = 0;
    int n_ref       = 0;
    int n_meas      = 0;
    int n_checked   = 0;
    int n_settings  = 0;
    int cycle_cnt   = 0;
    int in_gap_pct  = 0;
    int out_gap_pct = 0;
    int cfg_phase   = 0;

    function automatic longint gain_at(input logic [63:0] word, input int slot);
        logic signed [15:0] f;
        f = word[16*slot +: 16];
        return f;
    endfunction

    function automatic longint q_round(input longint acc);
        return (acc + (longint'(1) <<< (C_FRAC - 1))) >>> C_FRAC;
    endfunction

    function automatic longint q_sat(input longint v);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (C_DW - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    function automatic void set_register(input logic [C_IDX_W-1:0] idx,
                                         input logic [C_CFG_W-1:0] data);
        case (idx)
            CFG_FEEDBACK_GAINS: fb_gains = data[47:0];
            CFG_MODEL_A:        mdl_a    = data;
            CFG_MODEL_B_C:      mdl_bc   = data;
            CFG_OBSERVER_GAIN:  obs_gain = data[31:0];
            CFG_DRIVE_OFFSET:   drv_ofs  = data[15:0];
            CFG_DRIVE_MIN:      drv_min  = data[15:0];
            CFG_DRIVE_MAX:      drv_max  = data[15:0];
            default: ;
        endcase
    endfunction

    function automatic drive_result_t control_step(input logic typ,
                                                   input logic signed [C_DW-1:0] smp);
        longint        s;
        longint        x1;
        longint        x2;
        longint        u;
        longint        d;
        longint        c;
        longint        cz;
        longint        innov;
        drive_result_t r;
        s  = smp;
        x1 = est_st[0];
        x2 = est_st[1];
        r  = '0;
        if (typ == REQ_REFERENCE) begin
            u = q_round(gain_at(fb_gains, 0) * s - gain_at(fb_gains, 1) * x1
                        - gain_at(fb_gains, 2) * x2);
            pred_st[0] = q_sat(q_round(gain_at(mdl_a, 0) * x1 + gain_at(mdl_a, 1) * x2
                                       + gain_at(mdl_bc, 0) * u));
            pred_st[1] = q_sat(q_round(gain_at(mdl_a, 2) * x1 + gain_at(mdl_a, 3) * x2
                                       + gain_at(mdl_bc, 1) * u));
            d = u + longint'(drv_ofs);
            c = d;
            // raise first, then lower, so crossed limits end at the upper one
            if (c < longint'(drv_min)) c = drv_min;
            if (c > longint'(drv_max)) c = drv_max;
            r.drive         = c[15:0];
            r.drive_valid   = 1'b1;
            r.drive_clipped = (c != d);
        end else begin
            cz = q_round(gain_at(mdl_bc, 2) * pred_st[0] + gain_at(mdl_bc, 3) * pred_st[1]);
            innov = s - cz;
            est_st[0] = q_sat(pred_st[0] + q_round(gain_at(obs_gain, 0) * innov));
            est_st[1] = q_sat(pred_st[1] + q_round(gain_at(obs_gain, 1) * innov));
        end
        r.est_first  = est_st[0][15:0];
        r.est_second = est_st[1][15:0];
        return r;
    endfunction

    function automatic stim_row_t row_cfg(input logic [C_IDX_W-1:0] idx,
                                          input logic [C_CFG_W-1:0] data);
        stim_row_t r;
        r      = '0;
        r.kind = ROW_CFG;
        r.idx  = idx;
        r.data = data;
        return r;
    endfunction

    function automatic stim_row_t row_item(input logic typ, input logic [C_DW-1:0] s);
        stim_row_t r;
        r          = '0;
        r.kind     = ROW_ITEM;
        r.req_type = typ;
        r.sample   = s;
        return r;
    endfunction

    function automatic stim_row_t row_checked(input logic typ, input logic [C_DW-1:0] s,
                                              input logic [C_DW-1:0] drive,
                                              input logic dv, input logic clip,
                                              input logic [C_DW-1:0] e1,
                                              input logic [C_DW-1:0] e2);
        stim_row_t r;
        r       = row_item(typ, s);
        r.kind  = ROW_CHECKED;
        r.given = '{drive: drive, drive_valid: dv, drive_clipped: clip,
                    est_first: e1, est_second: e2};
        return r;
    endfunction

    function automatic logic [C_DW-1:0] pick_extreme();
        case ($urandom_range(0, 3))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'h0000;
            default: return 16'h1000;
        endcase
    endfunction

    function automatic logic [C_DW-1:0] pick_coef();
        int r;
        int v;
        if (cfg_phase == 0) return pick_extreme();
        if (cfg_phase == 1) return 16'($urandom);
        r = $urandom_range(0, 9);
        if (r == 0) return 16'($urandom);
        if (r == 1) return pick_extreme();
        v = $urandom_range(0, 16'h3000) - 16'h1800;
        return v[15:0];
    endfunction

    function automatic logic [C_DW-1:0] pick_sample();
        int v;
        if ($urandom_range(0, 1) == 0) return 16'($urandom);
        v = $urandom_range(0, 16'h4000) - 16'h2000;
        return v[15:0];
    endfunction

    function automatic void queue_write(input logic [C_IDX_W-1:0] idx,
                                        input logic [C_CFG_W-1:0] data);
        pending_writes.push_back('{idx: idx, data: data});
    endfunction

    function automatic void check_field(input string name, input logic signed [15:0] want,
                                        input logic signed [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endfunction

    task automatic apply_config();
        i_in_valid <= 1'b0;
        while (drive_estimate_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        foreach (pending_writes[k]) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= pending_writes[k].idx;
            i_cfg_data <= pending_writes[k].data;
            set_register(pending_writes[k].idx, pending_writes[k].data);
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        pending_writes.delete();
        n_settings++;
    endtask

    task automatic send_item(input logic typ, input logic [C_DW-1:0] s,
                             input logic use_given, input drive_result_t given);
        drive_result_t predicted;
        if (in_gap_pct != 0 && $urandom_range(0, 99) < in_gap_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_in_req_type     <= typ;
        i_in_sample_value <= s;
        do @(posedge i_clk); while (!o_in_ready);
        predicted = control_step(typ, s);
        drive_estimate_q.push_back(use_given ? given : predicted);
        if (typ == REQ_REFERENCE) n_ref++;
        else n_meas++;
    endtask

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("[current_estimator_state_feedback_core] ERROR");
        $finish;
    end

    // result side: bursty back-pressure and in-order comparison
    initial begin
        int stall;
        drive_result_t want;
        stall = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid === 1'b1 && i_out_ready) begin
                if (drive_estimate_q.size() == 0) begin
                    $error("result item with nothing expected");
                    fails++;
                end else begin
                    want = drive_estimate_q.pop_front();
                    check_field("drive", want.drive, o_out_drive);
                    check_field("drive_valid", want.drive_valid, o_out_drive_valid);
                    check_field("drive_clipped", want.drive_clipped, o_out_drive_clipped);
                    check_field("estimate_first", want.est_first, o_out_estimate_first);
                    check_field("estimate_second", want.est_second, o_out_estimate_second);
                    n_checked++;
                end
            end
            if (stall > 0) begin
                stall--;
                i_out_ready <= 1'b0;
            end else if (out_gap_pct != 0 && $urandom_range(0, 99) < out_gap_pct) begin
                stall = $urandom_range(1, 14) - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin
        int lo;
        int hi;
        int sent;
        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_idx         <= '0;
        i_cfg_data        <= '0;
        i_in_valid        <= 1'b0;
        i_in_req_type     <= 1'b0;
        i_in_sample_value <= '0;
        fb_gains   = '0;
        mdl_a      = '0;
        mdl_bc     = '0;
        obs_gain   = '0;
        drv_ofs    = '0;
        drv_min    = '0;
        drv_max    = C_DRIVE_MAX_RST;
        est_st[0]  = 0;
        est_st[1]  = 0;
        pred_st[0] = 0;
        pred_st[1] = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // correction before any reference, then clamp corners at reset gains
        directed_rows.push_back(row_checked(REQ_MEASUREMENT, 16'h7fff, 16'h0000, 0, 0, 0, 0));
        directed_rows.push_back(row_checked(REQ_REFERENCE, 16'h8000, 16'h0000, 1, 0, 0, 0));
        directed_rows.push_back(row_cfg(CFG_DRIVE_OFFSET, 64'h0000_0000_0000_8000));
        directed_rows.push_back(row_checked(REQ_REFERENCE, 16'h7fff, 16'h0000, 1, 1, 0, 0));
        directed_rows.push_back(row_cfg(CFG_DRIVE_OFFSET, 64'hffff_ffff_ffff_7fff));
        directed_rows.push_back(row_checked(REQ_REFERENCE, 16'h0000, 16'h4000, 1, 1, 0, 0));
        // crossed limits
        directed_rows.push_back(row_cfg(CFG_DRIVE_MIN, 64'h0000_0000_0000_7fff));
        directed_rows.push_back(row_cfg(CFG_DRIVE_MAX, 64'h0000_0000_0000_8000));
        directed_rows.push_back(row_checked(REQ_REFERENCE, 16'h0000, 16'h8000, 1, 1, 0, 0));
        directed_rows.push_back(row_cfg(CFG_DRIVE_OFFSET, 64'h0000_0000_0000_0000));
        directed_rows.push_back(row_cfg(CFG_DRIVE_MIN, 64'h0000_0000_0000_8000));
        directed_rows.push_back(row_cfg(CFG_DRIVE_MAX, 64'h0000_0000_0000_7fff));
        directed_rows.push_back(row_cfg(CFG_UNUSED, 64'hffff_ffff_ffff_ffff));
        directed_rows.push_back(row_checked(REQ_REFERENCE, 16'h1234, 16'h0000, 1, 0, 0, 0));
        // full-scale gains and model
        directed_rows.push_back(row_cfg(CFG_FEEDBACK_GAINS, 64'hffff_7fff_8000_7fff));
        directed_rows.push_back(row_cfg(CFG_MODEL_A, 64'h7fff_8000_8000_7fff));
        directed_rows.push_back(row_cfg(CFG_MODEL_B_C, 64'h8000_7fff_8000_7fff));
        directed_rows.push_back(row_cfg(CFG_OBSERVER_GAIN, 64'hdead_beef_8000_7fff));
        directed_rows.push_back(row_item(REQ_REFERENCE, 16'h7fff));
        directed_rows.push_back(row_item(REQ_REFERENCE, 16'h8000));
        directed_rows.push_back(row_item(REQ_MEASUREMENT, 16'h7fff));
        directed_rows.push_back(row_item(REQ_MEASUREMENT, 16'h8000));
        directed_rows.push_back(row_item(REQ_MEASUREMENT, 16'h0000));
        directed_rows.push_back(row_item(REQ_REFERENCE, 16'h0001));
        directed_rows.push_back(row_item(REQ_REFERENCE, 16'hffff));
        directed_rows.push_back(row_item(REQ_MEASUREMENT, 16'h4000));
        // moderate loop
        directed_rows.push_back(row_cfg(CFG_FEEDBACK_GAINS, 64'h0000_0400_0800_1000));
        directed_rows.push_back(row_cfg(CFG_MODEL_A, 64'h0f00_ff00_0100_1000));
        directed_rows.push_back(row_cfg(CFG_MODEL_B_C, 64'h0000_1000_0080_0010));
        directed_rows.push_back(row_cfg(CFG_OBSERVER_GAIN, 64'h0000_0000_0800_0400));
        directed_rows.push_back(row_cfg(CFG_DRIVE_OFFSET, 64'h0000_0000_0000_2000));
        directed_rows.push_back(row_cfg(CFG_DRIVE_MIN, 64'h0000_0000_0000_0000));
        directed_rows.push_back(row_cfg(CFG_DRIVE_MAX, 64'h0000_0000_0000_4000));
        directed_rows.push_back(row_item(REQ_REFERENCE, 16'h0800));
        directed_rows.push_back(row_item(REQ_MEASUREMENT, 16'h0100));
        directed_rows.push_back(row_item(REQ_REFERENCE, 16'h0800));
        directed_rows.push_back(row_item(REQ_MEASUREMENT, 16'h0200));
        directed_rows.push_back(row_item(REQ_REFERENCE, 16'hf800));
        directed_rows.push_back(row_item(REQ_MEASUREMENT, 16'hff00));

        in_gap_pct  = 30;
        out_gap_pct = 30;
        foreach (directed_rows[k]) begin
            if (directed_rows[k].kind == ROW_CFG) begin
                queue_write(directed_rows[k].idx, directed_rows[k].data);
            end else begin
                if (pending_writes.size() != 0) apply_config();
                send_item(directed_rows[k].req_type, directed_rows[k].sample,
                          directed_rows[k].kind == ROW_CHECKED, directed_rows[k].given);
            end
        end

        for (int p = 0; p < N_PHASES; p++) begin
            cfg_phase = p;
            queue_write(CFG_FEEDBACK_GAINS, {16'($urandom), pick_coef(), pick_coef(),
                                             pick_coef()});
            queue_write(CFG_MODEL_A, {pick_coef(), pick_coef(), pick_coef(), pick_coef()});
            queue_write(CFG_MODEL_B_C, {pick_coef(), pick_coef(), pick_coef(), pick_coef()});
            queue_write(CFG_OBSERVER_GAIN, {32'($urandom), pick_coef(), pick_coef()});
            if (p == 0) begin
                lo = -32768;
                hi = 32767;
            end else begin
                case ($urandom_range(0, 5))
                    0: begin
                        lo = -32768;
                        hi = 32767;
                    end
                    1: begin
                        lo = $urandom_range(0, 16'h3000);
                        hi = lo - $urandom_range(1, 16'h3000);
                    end
                    2: begin
                        lo = $signed(16'($urandom));
                        hi = $signed(16'($urandom));
                    end
                    default: begin
                        lo = -$urandom_range(0, 16'h3000);
                        hi = lo + $urandom_range(16'h0800, 16'h6000);
                    end
                endcase
            end
            queue_write(CFG_DRIVE_OFFSET, {48'({$urandom, $urandom}),
                                           (p == 0) ? pick_extreme() : pick_coef()});
            queue_write(CFG_DRIVE_MIN, {48'({$urandom, $urandom}), lo[15:0]});
            queue_write(CFG_DRIVE_MAX, {48'({$urandom, $urandom}), hi[15:0]});
            if ($urandom_range(0, 2) == 0) queue_write(CFG_UNUSED, {$urandom, $urandom});
            apply_config();

            case (p % 3)
                0: begin
                    in_gap_pct  = 0;
                    out_gap_pct = 40;
                end
                1: begin
                    in_gap_pct  = 40;
                    out_gap_pct = 0;
                end
                default: begin
                    in_gap_pct  = 25;
                    out_gap_pct = 25;
                end
            endcase
            if (p == N_PHASES - 1) begin
                in_gap_pct  = 0;
                out_gap_pct = 0;
            end

            // mostly reference then measurement, as the loop runs in use
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                if ($urandom_range(0, 9) < 8) begin
                    send_item(REQ_REFERENCE, pick_sample(), 1'b0, '0);
                    send_item(REQ_MEASUREMENT, pick_sample(), 1'b0, '0);
                    sent += 2;
                end else begin
                    send_item(1'($urandom_range(0, 1)), pick_sample(), 1'b0, '0);
                    sent++;
                end
            end
        end

        i_in_valid <= 1'b0;
        while (drive_estimate_q.size() != 0) @(posedge i_clk);
        repeat (2 * SETTLE) @(posedge i_clk);
        $display("run covered %0d reference and %0d measurement items", n_ref, n_meas);
        $display("over %0d register settings, %0d results compared", n_settings, n_checked);
        if (fails == 0 && drive_estimate_q.size() == 0) begin
            $display("[current_estimator_state_feedback_core] OK");
        end else begin
            $display("[current_estimator_state_feedback_core] ERROR");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/cesf_pkg.sv
hw/rtl/cesf_ctrl.sv
hw/rtl/cesf_dp.sv
hw/rtl/current_estimator_state_feedback_core.sv
tb/sv/tb_top.sv
